// ===== sv/complex_arithmetic_unit_core_macros.svh =====
// Assertion macros shared by the complex arithmetic unit RTL
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// antecedent implies consequent on the same edge
`define CAU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cau assertion failed");

// expression must never hold
`define CAU_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("cau assertion failed");

`endif

// ===== sv/cau_pkg.sv =====
// Types, widths and helper functions for the complex arithmetic unit
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PW        = 2 * WORD_BITS;          // product width
  localparam int XW        = PW + 1;                 // widened sum width
  localparam int SW        = WORD_BITS + 1;          // add/sub width
  localparam int NW        = PW + FRAC_BITS;         // scaled dividend width
  localparam int TW        = NW - WORD_BITS;         // dividend head width
  localparam int LATENCY   = WORD_BITS + 5;          // accept edge to result sample edge

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_EQ   = 3'd5
  } op_t;

  typedef struct packed {
    logic [PW-1:0]        rem;
    logic [WORD_BITS-1:0] quo;
    logic [WORD_BITS-1:0] num;
    logic                 neg;
    logic                 big;
  } lane_t;

  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 dz;
    lane_t                re;
    lane_t                im;
    logic [PW-1:0]        den;
    logic [WORD_BITS-1:0] res_re;
    logic [WORD_BITS-1:0] res_im;
    logic                 eq;
    logic                 ov;
  } flow_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 ov;
  } fit_t;

  localparam logic [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic fit_t sat_fit(input logic signed [XW-1:0] v);
    fit_t                     r;
    logic [XW-WORD_BITS:0]    head;
    head = v[XW-1:WORD_BITS-1];
    if (head == '0 || head == '1) begin
      r.val = v[WORD_BITS-1:0];
      r.ov  = 1'b0;
    end else begin
      r.val = v[XW-1] ? SAT_MIN : SAT_MAX;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

  // one restoring division step: bring in the next dividend bit
  function automatic lane_t step_lane(input lane_t l, input logic [PW-1:0] den);
    lane_t       r;
    logic [PW:0] t;
    logic [PW:0] diff;
    logic        qb;
    r    = l;
    t    = {l.rem, l.num[WORD_BITS-1]};
    diff = t - {1'b0, den};
    qb   = (t >= {1'b0, den});
    r.rem = qb ? diff[PW-1:0] : t[PW-1:0];
    r.num = {l.num[WORD_BITS-2:0], 1'b0};
    r.quo = {l.quo[WORD_BITS-2:0], qb};
    return r;
  endfunction

  function automatic fit_t fit_quo(input lane_t l);
    fit_t r;
    r.ov  = 1'b0;
    r.val = l.quo;
    if (l.big) begin
      r.ov  = 1'b1;
      r.val = l.neg ? SAT_MIN : SAT_MAX;
    end else if (l.neg) begin
      if (l.quo > SAT_MIN) begin
        r.ov  = 1'b1;
        r.val = SAT_MIN;
      end else begin
        r.val = '0 - l.quo;
      end
    end else if (l.quo[WORD_BITS-1]) begin
      r.ov  = 1'b1;
      r.val = SAT_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/cau_front.sv =====
// Front stages: operand capture, products, sums, scaling and divider set-up
module cau_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_vld,
  input  logic [2:0]                              in_mode,
  input  logic signed [cau_pkg::WORD_BITS-1:0]    in_a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0]    in_a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0]    in_b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0]    in_b_im,
  output cau_pkg::flow_t                          flow_o
);

  // stage 1: operands
  logic                                  s1_vld_r;
  cau_pkg::op_t                          s1_op_r;
  logic signed [cau_pkg::WORD_BITS-1:0]  s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  // stage 2: products and simple results
  logic                                  s2_vld_r;
  cau_pkg::op_t                          s2_op_r;
  logic signed [cau_pkg::PW-1:0]         p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_bb_r, p_cc_r;
  logic signed [cau_pkg::SW-1:0]         s2_sre_r, s2_sim_r;
  logic signed [cau_pkg::SW-1:0]         s2_sre_nxt, s2_sim_nxt;
  logic                                  s2_eq_r;

  // stage 3: wide sums
  logic                                  s3_vld_r;
  cau_pkg::op_t                          s3_op_r;
  logic signed [cau_pkg::XW-1:0]         s3_xr_r, s3_xi_r, s3_xr_nxt, s3_xi_nxt;
  logic [cau_pkg::PW-1:0]                s3_den_r;
  logic                                  s3_eq_r;

  // stage 4: fitted results or divider set-up
  logic                                  s4_vld_r;
  cau_pkg::flow_t                        s4_r, s4_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= cau_pkg::op_t'(in_mode);
    s1_ar_r  <= in_a_re;
    s1_ai_r  <= in_a_im;
    s1_br_r  <= in_b_re;
    s1_bi_r  <= in_b_im;

    s2_op_r  <= s1_op_r;
    p_rr_r   <= s1_ar_r * s1_br_r;
    p_ii_r   <= s1_ai_r * s1_bi_r;
    p_ir_r   <= s1_ai_r * s1_br_r;
    p_ri_r   <= s1_ar_r * s1_bi_r;
    p_bb_r   <= s1_br_r * s1_br_r;
    p_cc_r   <= s1_bi_r * s1_bi_r;
    s2_sre_r <= s2_sre_nxt;
    s2_sim_r <= s2_sim_nxt;
    s2_eq_r  <= (s1_ar_r == s1_br_r) && (s1_ai_r == s1_bi_r);

    s3_op_r  <= s2_op_r;
    s3_xr_r  <= s3_xr_nxt;
    s3_xi_r  <= s3_xi_nxt;
    s3_den_r <= $unsigned(p_bb_r) + $unsigned(p_cc_r);
    s3_eq_r  <= s2_eq_r;

    s4_r     <= s4_nxt;
  end

  always_comb begin
    s2_sre_nxt = '0;
    s2_sim_nxt = '0;
    case (s1_op_r)
      cau_pkg::OP_ADD: begin
        s2_sre_nxt = cau_pkg::SW'(s1_ar_r) + cau_pkg::SW'(s1_br_r);
        s2_sim_nxt = cau_pkg::SW'(s1_ai_r) + cau_pkg::SW'(s1_bi_r);
      end
      cau_pkg::OP_SUB: begin
        s2_sre_nxt = cau_pkg::SW'(s1_ar_r) - cau_pkg::SW'(s1_br_r);
        s2_sim_nxt = cau_pkg::SW'(s1_ai_r) - cau_pkg::SW'(s1_bi_r);
      end
      cau_pkg::OP_CONJ: begin
        s2_sre_nxt = cau_pkg::SW'(s1_ar_r);
        s2_sim_nxt = -cau_pkg::SW'(s1_ai_r);
      end
      default: begin
        s2_sre_nxt = '0;
        s2_sim_nxt = '0;
      end
    endcase
  end

  always_comb begin
    case (s2_op_r)
      cau_pkg::OP_MUL: begin
        s3_xr_nxt = cau_pkg::XW'(p_rr_r) - cau_pkg::XW'(p_ii_r);
        s3_xi_nxt = cau_pkg::XW'(p_ir_r) + cau_pkg::XW'(p_ri_r);
      end
      cau_pkg::OP_DIV: begin
        s3_xr_nxt = cau_pkg::XW'(p_rr_r) + cau_pkg::XW'(p_ii_r);
        s3_xi_nxt = cau_pkg::XW'(p_ir_r) - cau_pkg::XW'(p_ri_r);
      end
      default: begin
        s3_xr_nxt = cau_pkg::XW'(s2_sre_r);
        s3_xi_nxt = cau_pkg::XW'(s2_sim_r);
      end
    endcase
  end

  // truncate toward zero while dropping the fraction bits
  function automatic logic signed [cau_pkg::XW-1:0] scale_down(
      input logic signed [cau_pkg::XW-1:0] v);
    logic signed [cau_pkg::XW-1:0] bias;
    bias = v[cau_pkg::XW-1] ?
        ((cau_pkg::XW'(1) <<< cau_pkg::FRAC_BITS) - cau_pkg::XW'(1)) : '0;
    return (v + bias) >>> cau_pkg::FRAC_BITS;
  endfunction

  function automatic cau_pkg::lane_t prep_lane(input logic signed [cau_pkg::XW-1:0] v,
                                               input logic [cau_pkg::PW-1:0] den);
    cau_pkg::lane_t          l;
    logic [cau_pkg::XW-1:0]  mag;
    logic [cau_pkg::NW-1:0]  num;
    logic [cau_pkg::TW-1:0]  head;
    l.neg = v[cau_pkg::XW-1];
    mag   = l.neg ? -v : v;
    num   = cau_pkg::NW'(mag[cau_pkg::PW-1:0]) << cau_pkg::FRAC_BITS;
    head  = num[cau_pkg::NW-1:cau_pkg::WORD_BITS];
    l.big = (cau_pkg::PW'(head) >= den);
    l.rem = l.big ? '0 : cau_pkg::PW'(head);
    l.num = num[cau_pkg::WORD_BITS-1:0];
    l.quo = '0;
    return l;
  endfunction

  always_comb begin
    cau_pkg::fit_t fr, fi;
    fr = '0;
    fi = '0;
    s4_nxt        = '0;
    s4_nxt.den    = s3_den_r;
    s4_nxt.re     = prep_lane(s3_xr_r, s3_den_r);
    s4_nxt.im     = prep_lane(s3_xi_r, s3_den_r);
    case (s3_op_r)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
        fr = cau_pkg::sat_fit(s3_xr_r);
        fi = cau_pkg::sat_fit(s3_xi_r);
      end
      cau_pkg::OP_MUL: begin
        fr = cau_pkg::sat_fit(scale_down(s3_xr_r));
        fi = cau_pkg::sat_fit(scale_down(s3_xi_r));
      end
      cau_pkg::OP_DIV: begin
        s4_nxt.dz     = (s3_den_r == '0);
        s4_nxt.is_div = (s3_den_r != '0);
      end
      cau_pkg::OP_EQ: begin
        s4_nxt.eq = s3_eq_r;
      end
      default: begin
        s4_nxt.eq = 1'b0;
      end
    endcase
    s4_nxt.res_re = fr.val;
    s4_nxt.res_im = fi.val;
    s4_nxt.ov     = fr.ov | fi.ov;
  end

  // the valid bit comes from its own reset register
  always_comb begin
    flow_o     = s4_r;
    flow_o.vld = s4_vld_r;
  end

endmodule

// ===== sv/cau_div_step.sv =====
// One registered restoring division step for both quotient parts
module cau_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  cau_pkg::flow_t flow_i,
  output cau_pkg::flow_t flow_o
);

  logic           vld_r;
  cau_pkg::flow_t flow_r, flow_nxt;

  always_comb begin
    flow_nxt    = flow_i;
    flow_nxt.re = cau_pkg::step_lane(flow_i.re, flow_i.den);
    flow_nxt.im = cau_pkg::step_lane(flow_i.im, flow_i.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= flow_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    flow_r <= flow_nxt;
  end

  // the valid bit comes from its own reset register
  always_comb begin
    flow_o     = flow_r;
    flow_o.vld = vld_r;
  end

endmodule

// ===== sv/cau_back.sv =====
// Output stage: quotient sign and saturation, result register
module cau_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cau_pkg::flow_t                       flow_i,
  output logic                                 out_valid,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_im,
  output logic                                 out_is_equal,
  output logic                                 out_div_zero,
  output logic                                 out_overflowed
);

  logic                           vld_r;
  logic [cau_pkg::WORD_BITS-1:0]  re_r, im_r, re_nxt, im_nxt;
  logic                           eq_r, dz_r, ov_r, ov_nxt;

  always_comb begin
    cau_pkg::fit_t qr, qi;
    qr = cau_pkg::fit_quo(flow_i.re);
    qi = cau_pkg::fit_quo(flow_i.im);
    if (flow_i.is_div) begin
      re_nxt = qr.val;
      im_nxt = qi.val;
      ov_nxt = qr.ov | qi.ov;
    end else begin
      re_nxt = flow_i.res_re;
      im_nxt = flow_i.res_im;
      ov_nxt = flow_i.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= flow_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
    eq_r <= flow_i.eq;
    dz_r <= flow_i.dz;
    ov_r <= ov_nxt;
  end

  assign out_valid      = vld_r;
  assign out_res_re     = re_r;
  assign out_res_im     = im_r;
  assign out_is_equal   = eq_r;
  assign out_div_zero   = dz_r;
  assign out_overflowed = ov_r;

endmodule

// ===== sv/complex_arithmetic_unit_core.sv =====
// A result strobes on out_valid once its accepted transaction has passed every stage.
// Throughput: one transaction per cycle; busy stays low and never holds start off.
// The stages are four front stages, one divider stage per quotient bit and the output register.
// Every mode walks the same stages, so results leave in order.
// Synchronous active-low reset clears the stage valid bits; data registers are not reset.
`include "complex_arithmetic_unit_core_macros.svh"

module complex_arithmetic_unit_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_mode,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_im,
  output logic                                 out_valid,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_im,
  output logic                                 out_is_equal,
  output logic                                 out_div_zero,
  output logic                                 out_overflowed
);

  cau_pkg::flow_t chain [0:cau_pkg::WORD_BITS];

  assign busy = 1'b0;

  cau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start & ~busy),
    .in_mode (in_mode),
    .in_a_re (in_a_re),
    .in_a_im (in_a_im),
    .in_b_re (in_b_re),
    .in_b_im (in_b_im),
    .flow_o  (chain[0])
  );

  // one quotient bit per stage
  for (genvar i = 0; i < cau_pkg::WORD_BITS; i++) begin : g_div
    cau_div_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .flow_i (chain[i]),
      .flow_o (chain[i+1])
    );
  end

  cau_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .flow_i         (chain[cau_pkg::WORD_BITS]),
    .out_valid      (out_valid),
    .out_res_re     (out_res_re),
    .out_res_im     (out_res_im),
    .out_is_equal   (out_is_equal),
    .out_div_zero   (out_div_zero),
    .out_overflowed (out_overflowed)
  );

  `CAU_ASSERT_IMPL(a_out_has_source, out_valid, $past(start, cau_pkg::LATENCY))
  `CAU_ASSERT_NEVER(a_dz_and_ov, out_valid && out_div_zero && out_overflowed)
  `CAU_ASSERT_IMPL(a_eq_zero_parts, out_valid && out_is_equal, out_res_re == 0 && out_res_im == 0)
  `CAU_ASSERT_IMPL(a_dz_zero_parts, out_valid && out_div_zero, out_res_re == 0 && out_res_im == 0)

endmodule
